### hw/rtl/hrht_pkg.sv
// ---------------------------------------------------------------------------
// hrht_pkg: shared types and constants for the HTTP header tokenizer
// Word formats for both channels, phase codes and the character codes
// that the tokenizer recognizes.
// ---------------------------------------------------------------------------
package hrht_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } hrht_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_kept;
        logic [2:0] token_kind;
        logic       token_end;
        logic       request_done;
        logic       parse_error;
    } hrht_out_t;

    // Parser phases; token_kind uses the same codes for the first five.
    localparam logic [2:0] PH_METHOD  = 3'd0;
    localparam logic [2:0] PH_PATH    = 3'd1;
    localparam logic [2:0] PH_VERSION = 3'd2;
    localparam logic [2:0] PH_NAME    = 3'd3;
    localparam logic [2:0] PH_VALUE   = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_PATH_LO = 8'h21;
    localparam logic [7:0] CH_PATH_HI = 8'h7E;

    localparam logic [1:0] HDR_CNT_MAX = 2'd3;

endpackage

### hw/rtl/hrht_parser.sv
// ---------------------------------------------------------------------------
// hrht_parser: phase tracker and byte classifier
// Holds the parser state and classifies one input word per advance,
// producing the result word that goes to the output register.
// ---------------------------------------------------------------------------
module hrht_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  hrht_pkg::hrht_in_t  item,
    output hrht_pkg::hrht_out_t result
);
    import hrht_pkg::*;

    logic [2:0] phase_reg, phase_next;
    logic       cr_seen_reg, cr_seen_next;
    logic       colon_seen_reg, colon_seen_next;
    logic [1:0] hdr_cnt_reg, hdr_cnt_next;

    logic       kept;
    logic       tok_end;
    logic       done;
    logic       err;
    logic [7:0] c;

    assign c = item.data_byte;

    always_comb begin
        phase_next      = phase_reg;
        cr_seen_next    = cr_seen_reg;
        colon_seen_next = colon_seen_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        kept            = 1'b0;
        tok_end         = 1'b0;
        done            = 1'b0;
        err             = 1'b0;

        if (phase_reg > PH_VALUE) begin
            err = 1'b1;
        end else if (item.stream_end) begin
            // only legal right after a completed request
            if (!(phase_reg == PH_METHOD && cr_seen_reg)) begin
                err = 1'b1;
            end
        end else begin
            unique case (phase_reg) inside
                PH_METHOD: begin
                    cr_seen_next = 1'b0;
                    if (c == CH_SP) begin
                        tok_end    = 1'b1;
                        phase_next = PH_PATH;
                    end else if (c >= CH_A && c <= CH_Z) begin
                        kept = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_PATH: begin
                    if (c == CH_SP) begin
                        tok_end    = 1'b1;
                        phase_next = PH_VERSION;
                    end else if (c >= CH_PATH_LO && c <= CH_PATH_HI) begin
                        kept = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_VERSION, PH_VALUE: begin
                    if (c == CH_CR) begin
                        cr_seen_next = 1'b1;
                    end else if (c == CH_LF) begin
                        if (cr_seen_reg) begin
                            tok_end         = 1'b1;
                            phase_next      = PH_NAME;
                            cr_seen_next    = 1'b0;
                            colon_seen_next = 1'b0;
                            hdr_cnt_next    = 2'd0;
                        end else begin
                            err = 1'b1;
                        end
                    end else begin
                        kept         = 1'b1;
                        cr_seen_next = 1'b0;
                    end
                end
                PH_NAME: begin
                    if (hdr_cnt_reg != HDR_CNT_MAX) begin
                        hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    end
                    if (c == CH_CR) begin
                        if (hdr_cnt_reg == 2'd0) begin
                            cr_seen_next = 1'b1;
                        end
                    end else if (c == CH_LF) begin
                        // blank line: request complete, mark it for stream end
                        if (hdr_cnt_reg == 2'd1 && cr_seen_reg) begin
                            done            = 1'b1;
                            phase_next      = PH_METHOD;
                            cr_seen_next    = 1'b1;
                            colon_seen_next = 1'b0;
                            hdr_cnt_next    = 2'd0;
                        end
                    end else if (c == CH_COLON) begin
                        colon_seen_next = 1'b1;
                    end else if (c == CH_SP) begin
                        if (colon_seen_reg) begin
                            tok_end         = 1'b1;
                            phase_next      = PH_VALUE;
                            cr_seen_next    = 1'b0;
                            colon_seen_next = 1'b0;
                            hdr_cnt_next    = 2'd0;
                        end else begin
                            err = 1'b1;
                        end
                    end else begin
                        kept            = 1'b1;
                        colon_seen_next = 1'b0;
                    end
                end
                default: begin
                    err = 1'b1;
                end
            endcase
        end

        if (err) begin
            phase_next      = PH_ERROR;
            cr_seen_next    = 1'b0;
            colon_seen_next = 1'b0;
            hdr_cnt_next    = 2'd0;
            kept            = 1'b0;
            tok_end         = 1'b0;
            done            = 1'b0;
        end
    end

    always_comb begin
        result.out_byte     = kept ? c : 8'd0;
        result.byte_kept    = kept;
        result.token_kind   = err ? PH_METHOD : phase_reg;
        result.token_end    = tok_end;
        result.request_done = done;
        result.parse_error  = err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_METHOD;
            cr_seen_reg    <= 1'b0;
            colon_seen_reg <= 1'b0;
            hdr_cnt_reg    <= 2'd0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            cr_seen_reg    <= cr_seen_next;
            colon_seen_reg <= colon_seen_next;
            hdr_cnt_reg    <= hdr_cnt_next;
        end
    end

endmodule

### hw/rtl/http_request_header_tokenizer.sv
// ---------------------------------------------------------------------------
// http_request_header_tokenizer: byte-wide HTTP/1.1 request header splitter
// Input register, classifier with phase state, output register.
// ---------------------------------------------------------------------------
// Feed the request one byte per word on s_; each input word yields exactly
// one result word on m_, in order. Throughput is one word per cycle while
// m_ready drains the result register; m_valid rises once the word has gone
// from the input register through the classifier into the result register.
// The result tells whether the byte is token text (byte_kept, out_byte),
// which token it belongs to (token_kind: method, path, version, header
// name, header value), and whether it closes a token, closes the request
// (blank line) or is malformed. CR and LF are never kept; a space is kept
// only as version or value text, a ':' only as path, version or value text.
// A word with stream_end set carries no byte; it is clean only right
// after a completed request. Once parse_error is reported, every later
// word reports it too, until aresetn is asserted.
// ---------------------------------------------------------------------------
module http_request_header_tokenizer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hrht_pkg::hrht_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hrht_pkg::hrht_out_t m_data
);
    import hrht_pkg::*;

    logic       in_valid_reg;
    hrht_in_t   in_data_reg;
    logic       out_valid_reg;
    hrht_out_t  out_data_reg;
    hrht_out_t  result;
    logic       advance;

    // Move the held word into the result register when that register is
    // empty or is being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    // Take a new word whenever the input register empties or advances.
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Payload register: no reset needed, valid qualifies it.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    hrht_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .result  (result)
    );

    // Result register: hold while stalled, load on advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

### hw/rtl/hrht_checker.sv
// ---------------------------------------------------------------------------
// hrht_port_checker: port-level checks for the HTTP header tokenizer
// Watches the top-level ports and flags inconsistent result words.
// ---------------------------------------------------------------------------
module hrht_port_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input hrht_pkg::hrht_out_t m_data
);
    import hrht_pkg::*;

    // Stalled result word must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // No result comes out the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // An error word carries no token information.
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.parse_error |->
            !m_data.byte_kept && !m_data.token_end && !m_data.request_done &&
            m_data.token_kind == PH_METHOD)
        else $error("error word carries token fields");

    // Dropped bytes read as zero; kept bytes are never CR or LF.
    a_kept_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.byte_kept ? (m_data.out_byte != CH_CR &&
            m_data.out_byte != CH_LF) :
            m_data.out_byte == 8'd0))
        else $error("out_byte inconsistent with byte_kept");

    // The blank line only ends in header name phase and keeps nothing.
    a_done_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.request_done |->
            m_data.token_kind == PH_NAME && !m_data.byte_kept && !m_data.token_end)
        else $error("request_done outside header name phase");

endmodule

bind http_request_header_tokenizer hrht_port_checker u_hrht_checker (.*);

### tb/sv/hrht_checker.sv
// ---------------------------------------------------------------------------
// hrht_checker: result predictor and scoreboard for the header tokenizer
// Watches both channels, computes the expected result word for every
// accepted input word and compares each accepted result word against it.
// ---------------------------------------------------------------------------
module hrht_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  hrht_pkg::hrht_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  hrht_pkg::hrht_out_t m_data,
    output int                  fail_count,
    output int                  pending_count
);

    import hrht_pkg::*;

    // Shadow of the tokenizer state
    logic [2:0] ph_q;
    logic       cr_q;
    logic       colon_q;
    logic [1:0] hdr_cnt_q;

    hrht_out_t  token_q[$];
    int         n_fail = 0;

    function automatic void go_phase(input logic [2:0] p);
        ph_q      = p;
        cr_q      = 1'b0;
        colon_q   = 1'b0;
        hdr_cnt_q = '0;
    endfunction

    function automatic hrht_out_t tokenize_byte(input hrht_in_t w);
        hrht_out_t  r;
        logic [7:0] c;
        logic       kept;
        logic       tend;
        logic       done;
        logic       err;
        logic [2:0] kind;
        logic [1:0] cnt_was;
        c    = w.data_byte;
        kept = 1'b0;
        tend = 1'b0;
        done = 1'b0;
        err  = 1'b0;
        kind = ph_q;
        if (ph_q > PH_VALUE) begin
            err = 1'b1;
        end else if (w.stream_end) begin
            err = !(ph_q == PH_METHOD && cr_q);
        end else begin
            case (ph_q)
                PH_METHOD: begin
                    cr_q = 1'b0;
                    if (c == CH_SP) begin
                        tend = 1'b1;
                        go_phase(PH_PATH);
                    end else if (c >= CH_A && c <= CH_Z) begin
                        kept = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_PATH: begin
                    if (c == CH_SP) begin
                        tend = 1'b1;
                        go_phase(PH_VERSION);
                    end else if (c >= CH_PATH_LO && c <= CH_PATH_HI) begin
                        kept = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_VERSION, PH_VALUE: begin
                    if (c == CH_CR) begin
                        cr_q = 1'b1;
                    end else if (c == CH_LF) begin
                        if (cr_q) begin
                            tend = 1'b1;
                            go_phase(PH_NAME);
                        end else begin
                            err = 1'b1;
                        end
                    end else begin
                        kept = 1'b1;
                        cr_q = 1'b0;
                    end
                end
                PH_NAME: begin
                    cnt_was = hdr_cnt_q;
                    if (hdr_cnt_q != HDR_CNT_MAX) hdr_cnt_q = hdr_cnt_q + 2'd1;
                    if (c == CH_CR) begin
                        if (cnt_was == 2'd0) cr_q = 1'b1;
                    end else if (c == CH_LF) begin
                        // blank line: CR LF as the first two bytes of a header
                        if (cnt_was == 2'd1 && cr_q) begin
                            done = 1'b1;
                            go_phase(PH_METHOD);
                            cr_q = 1'b1;
                        end
                    end else if (c == CH_COLON) begin
                        colon_q = 1'b1;
                    end else if (c == CH_SP) begin
                        if (colon_q) begin
                            tend = 1'b1;
                            go_phase(PH_VALUE);
                        end else begin
                            err = 1'b1;
                        end
                    end else begin
                        kept    = 1'b1;
                        colon_q = 1'b0;
                    end
                end
                default: err = 1'b1;
            endcase
        end
        if (err) begin
            go_phase(PH_ERROR);
            kept = 1'b0;
            tend = 1'b0;
            done = 1'b0;
            kind = PH_METHOD;
        end
        r.out_byte     = kept ? c : 8'h00;
        r.byte_kept    = kept;
        r.token_kind   = kind;
        r.token_end    = tend;
        r.request_done = done;
        r.parse_error  = err;
        return r;
    endfunction

    function automatic int field_bad(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : scoreboard
        hrht_out_t want;
        if (!aresetn) begin
            go_phase(PH_METHOD);
            token_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (token_q.size() == 0) begin
                    $error("result word with nothing expected: %p", m_data);
                    n_fail++;
                end else begin
                    want = token_q.pop_front();
                    n_fail += field_bad("out_byte", want.out_byte, m_data.out_byte);
                    n_fail += field_bad("byte_kept", 8'(want.byte_kept),
                                        8'(m_data.byte_kept));
                    n_fail += field_bad("token_kind", 8'(want.token_kind),
                                        8'(m_data.token_kind));
                    n_fail += field_bad("token_end", 8'(want.token_end),
                                        8'(m_data.token_end));
                    n_fail += field_bad("request_done", 8'(want.request_done),
                                        8'(m_data.request_done));
                    n_fail += field_bad("parse_error", 8'(want.parse_error),
                                        8'(m_data.parse_error));
                end
            end
            if (s_valid && s_ready) token_q.push_back(tokenize_byte(s_data));
        end
        pending_count <= token_q.size();
        fail_count    <= n_fail;
    end

endmodule

### tb/sv/tb_http_request_header_tokenizer.sv
// ---------------------------------------------------------------------------
// tb_http_request_header_tokenizer: stimulus and verdict for the tokenizer
// Feeds directed and random HTTP requests byte by byte with random gaps on
// both channels, ends with one malformed request and a sticky error tail;
// the checker beside the block predicts and compares every result word.
// ---------------------------------------------------------------------------
module tb_http_request_header_tokenizer;

    import hrht_pkg::*;

    localparam int WORD_TARGET  = 620;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_GAP      = 17;
    localparam int DRAIN_CYCLES = 8;

    typedef enum {
        FAULT_METHOD,
        FAULT_PATH,
        FAULT_VERSION_LF,
        FAULT_VALUE_LF,
        FAULT_NAME_SPACE,
        FAULT_EARLY_END
    } fault_kind_e;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    hrht_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    hrht_out_t m_data;

    int fail_count;
    int pending_count;

    int cycle_count   = 0;
    int words_sent    = 0;
    int requests_sent = 0;
    int tail_words    = 0;
    bit tx_no_idle    = 1'b0;
    bit rx_no_idle    = 1'b0;

    fault_kind_e fault_kind;

    // Directed request: extremes of the path range, 0x00/0xFF bytes, a lone
    // CR inside the version, and a header name with a leading CR, a stray LF
    // and a colon whose flag survives that LF.
    logic [7:0] directed_req[$] = '{
        CH_A, CH_Z, CH_SP,
        CH_PATH_LO, CH_PATH_HI, CH_SP,
        8'hFF, CH_CR, 8'h00, CH_CR, CH_LF,
        CH_CR, 8'h78, CH_COLON, CH_LF, CH_SP,
        8'hFF, CH_CR, CH_LF,
        CH_CR, CH_LF
    };

    // Empty method, empty path, empty version, no headers.
    logic [7:0] empty_req[$] = '{CH_SP, CH_SP, CH_CR, CH_LF, CH_CR, CH_LF};

    http_request_header_tokenizer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    hrht_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL http_request_header_tokenizer");
            $finish;
        end
    end

    function automatic int draw_gap(input bit no_idle);
        if (no_idle) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Receiver: after each accepted result word, drop ready for a drawn
    // number of cycles, then hold it high until the next word goes by.
    always @(posedge aclk) begin : result_sink
        int hold;
        if (!aresetn) begin
            hold = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) hold = draw_gap(rx_no_idle);
            else if (hold > 0) hold = hold - 1;
            m_ready <= (hold == 0);
        end
    end

    // Send one word. Valid goes low only for a nonzero gap, so back-to-back
    // words keep valid high and just advance the payload.
    task automatic send_word(input logic [7:0] b, input logic e);
        int gap;
        gap = draw_gap(tx_no_idle);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, stream_end: e};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    endtask

    task automatic send_crlf();
        send_word(CH_CR, 1'b0);
        send_word(CH_LF, 1'b0);
    endtask

    // Drop valid and hold off until every expected result word is back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // Any byte that can sit in a version or a value without ending it.
    function automatic logic [7:0] line_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
        return b;
    endfunction

    // Header name text: anything but the separators.
    function automatic logic [7:0] name_text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF || b == CH_SP || b == CH_COLON);
        return b;
    endfunction

    // Later name bytes mix text, colons and stray CR/LF. The first byte is
    // never CR, so a stray LF cannot be taken for the blank line.
    function automatic logic [7:0] name_byte(input bit first);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 3) return CH_COLON;
        if (!first && pick == 3) return CH_CR;
        if (!first && pick == 4) return CH_LF;
        return name_text_byte();
    endfunction

    task automatic send_request();
        int n;
        int hdrs;
        n = $urandom_range(0, 6);
        repeat (n) send_word(8'($urandom_range(CH_A, CH_Z)), 1'b0);
        send_word(CH_SP, 1'b0);
        n = $urandom_range(0, 8);
        repeat (n) send_word(8'($urandom_range(CH_PATH_LO, CH_PATH_HI)), 1'b0);
        send_word(CH_SP, 1'b0);
        n = $urandom_range(0, 8);
        repeat (n) send_word(line_byte(), 1'b0);
        send_crlf();
        hdrs = $urandom_range(0, 4);
        repeat (hdrs) begin
            send_word(name_byte(1'b1), 1'b0);
            n = $urandom_range(0, 5);
            repeat (n) send_word(name_byte(1'b0), 1'b0);
            send_word(CH_COLON, 1'b0);
            send_word(CH_SP, 1'b0);
            n = $urandom_range(0, 10);
            repeat (n) send_word(line_byte(), 1'b0);
            send_crlf();
        end
        send_crlf();
        // Clean stream ends right after the blank line; data is don't-care.
        if ($urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 2);
            repeat (n) send_word(8'($urandom_range(0, 255)), 1'b1);
        end
        requests_sent++;
    endtask

    // One malformed request; the parser starts in method phase here.
    task automatic send_fault(input fault_kind_e f);
        logic [7:0] b;
        case (f)
            FAULT_METHOD: begin
                do b = 8'($urandom_range(0, 255));
                while ((b >= CH_A && b <= CH_Z) || b == CH_SP);
                send_word(b, 1'b0);
            end
            FAULT_PATH: begin
                send_text("GET ");
                if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(0, CH_SP - 1));
                else b = 8'($urandom_range(CH_PATH_HI + 1, 255));
                send_word(b, 1'b0);
            end
            FAULT_VERSION_LF: begin
                // lone CR first, cleared by a kept byte, then a bare LF
                send_text("GET / H");
                send_word(CH_CR, 1'b0);
                send_text("x");
                send_word(CH_LF, 1'b0);
            end
            FAULT_VALUE_LF: begin
                send_text("GET / ");
                send_crlf();
                send_text("k: v");
                send_word(CH_LF, 1'b0);
            end
            FAULT_NAME_SPACE: begin
                // text after the colon clears it, so the space is illegal
                send_text("GET / ");
                send_crlf();
                send_text("k:z ");
            end
            default: begin
                send_text("GE");
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at full rate on both sides.
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        foreach (directed_req[i]) send_word(directed_req[i], 1'b0);
        send_word(8'hA5, 1'b1);
        foreach (empty_req[i]) send_word(empty_req[i], 1'b0);
        requests_sent += 2;
        drain();

        // Random well-formed requests; idling is switched per request.
        while (words_sent < WORD_TARGET) begin
            tx_no_idle = ($urandom_range(0, 3) == 0);
            rx_no_idle = ($urandom_range(0, 3) == 0);
            send_request();
            if (requests_sent % 6 == 0) drain();
        end
        drain();

        // Finish with one malformed request, then check that the error sticks.
        tx_no_idle = 1'b0;
        fault_kind = fault_kind_e'($urandom_range(FAULT_METHOD, FAULT_EARLY_END));
        send_fault(fault_kind);
        tail_words = $urandom_range(4, 8);
        repeat (tail_words)
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d words over %0d well-formed requests with random gaps",
                 words_sent, requests_sent);
        $display("Ended on a %s fault followed by %0d words in the error state",
                 fault_kind.name(), tail_words);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS http_request_header_tokenizer");
        end else begin
            $display("FAIL http_request_header_tokenizer");
        end
        $finish;
    end

endmodule
